// ----- rtl/core/tete_pkg.sv -----
// Shared types, constants and helper functions for the tag-enclosed text extractor.
// No dependencies; every other file in rtl/core imports this package.
package tete_pkg;

   localparam int TAG_BYTES = 8;
   localparam int TAG_LEN_W = $clog2(TAG_BYTES + 1);
   localparam int TAG_IDX_W = $clog2(TAG_BYTES);

   localparam int RESULT_DEPTH = 256;
   localparam int RESULT_ADDR_W = $clog2(RESULT_DEPTH);

   localparam int WINDOW_LIMIT = 240;
   localparam int WINDOW_MAX = (WINDOW_LIMIT < RESULT_DEPTH) ? WINDOW_LIMIT : RESULT_DEPTH;
   localparam logic [7:0] WINDOW_MAX_B = 8'(WINDOW_MAX);

   localparam logic [8:0] DEPTH_MAX = 9'h1FF;
   localparam logic [7:0] COUNT_MAX = 8'hFF;
   localparam logic [7:0] CHAR_LT = 8'h3C;
   localparam logic [7:0] CHAR_GT = 8'h3E;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W = CSR_ADDR_W - CSR_IDX_LSB;

   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int RSP_SUM_W = RSP_CNT_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_PATTERN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START_LENGTH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_END_PATTERN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_END_LENGTH = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CHARS = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_CASE_FOLD = CSR_IDX_W'(5);

   typedef enum logic [1:0] {
      PHASE_SEEK = 2'd0,
      PHASE_COLLECT = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [63:0] start_pattern;
      logic [3:0] start_length;
      logic [63:0] end_pattern;
      logic [3:0] end_length;
      logic [7:0] max_chars;
      logic case_fold;
   } cfg_type;

   typedef struct packed {
      logic byte_shift;
      logic hist_shift;
      logic hist_clear;
      logic case_fold;
   } cell_ctl_type;

   typedef struct packed {
      logic [7:0] result_char;
      logic [7:0] result_length;
      phase_type status;
   } rsp_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic [TAG_LEN_W-1:0] clamp_len(input logic [3:0] len);
      logic [TAG_LEN_W-1:0] r;
      if (len == 4'd0) begin
         r = TAG_LEN_W'(1);
      end else if (int'(len) > TAG_BYTES) begin
         r = TAG_LEN_W'(TAG_BYTES);
      end else begin
         r = TAG_LEN_W'(len);
      end
      return r;
   endfunction

   function automatic logic [7:0] pattern_byte(input logic [63:0] pattern,
                                               input logic [TAG_IDX_W-1:0] j);
      logic [63:0] shifted;
      shifted = pattern >> (8 * int'(j));
      return (int'(j) < 8) ? shifted[7:0] : 8'h00;
   endfunction

endpackage

// ----- rtl/core/tag_enclosed_text_extractor.sv -----
// Top level of the tag-enclosed text extractor: cell row, scan control, result memory.
// Depends on tete_pkg, tete_csr, tete_cell and tete_rsp_queue.
//
// The block takes one request beat per clock cycle unless req_stall is high, document
// bytes and result reads alike, and returns exactly one result beat for each; a result
// beat goes through the stage-one registers and then the result queue on its way to the
// result ports, since reads go through the registered port of the single-port result
// memory. The rate is set by the row of byte cells, which shifts and compares both tags
// in the cycle a byte arrives, and by a three-entry result queue that keeps requests
// flowing while the result side stalls, until it fills. Locations of the result memory
// that were never written hold no defined value, so there is no clearing pass after reset.
// Configuration must be written only while the block idles; the block does not enforce it.
module tag_enclosed_text_extractor import tete_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_type,
   input logic [7:0] req_doc_byte,
   input logic req_doc_last,
   input logic [7:0] req_read_index,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [7:0] rsp_result_char,
   output logic [7:0] rsp_result_length,
   output logic [1:0] rsp_status,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic pready
);

   cfg_type cfg;
   cell_ctl_type cell_ctl;

   phase_type phase_ff;
   phase_type phase_in;
   logic [7:0] bss_ff;
   logic [7:0] bss_in;
   logic [8:0] depth_ff;
   logic [8:0] depth_in;
   logic stopped_ff;
   logic stopped_in;
   logic [7:0] kept_ff;
   logic [7:0] kept_in;
   logic new_doc_ff;
   logic new_doc_in;

   phase_type cur_phase;
   logic [7:0] cur_bss;
   logic [8:0] cur_depth;
   logic cur_stopped;
   logic [7:0] cur_kept;
   logic [7:0] bss_inc;

   logic [TAG_LEN_W-1:0] sl;
   logic [TAG_LEN_W-1:0] el;
   logic [7:0] win;
   logic copy_ok;
   logic start_ok;
   logic end_ok;
   logic [7:0] end_tap;

   logic [7:0] recent [TAG_BYTES];
   logic [7:0] hist [TAG_BYTES];
   logic [7:0] hist_tap [TAG_BYTES];
   logic [TAG_BYTES-1:0] start_hits;
   logic [TAG_BYTES-1:0] end_hits;

   logic doc_acc;
   logic rd_acc;
   logic store_wr;
   logic [7:0] store_mem [RESULT_DEPTH];
   logic [7:0] rdata_ff;

   logic s1_valid_ff;
   logic [7:0] s1_length_ff;
   logic [7:0] s1_length_in;
   phase_type s1_status_ff;
   phase_type s1_status_in;
   logic s1_rd_ok_ff;
   logic s1_rd_ok_in;

   rsp_type push_data;
   rsp_type rsp_data;
   logic [RSP_CNT_W-1:0] fill;

   tete_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .cfg(cfg)
   );

   assign req_stall = (RSP_SUM_W'(fill) + RSP_SUM_W'(s1_valid_ff)) >= RSP_SUM_W'(RSP_DEPTH);
   assign doc_acc = req_valid && !req_stall && !req_type;
   assign rd_acc = req_valid && !req_stall && req_type;

   assign sl = clamp_len(cfg.start_length);
   assign el = clamp_len(cfg.end_length);
   assign win = (cfg.max_chars > WINDOW_MAX_B) ? WINDOW_MAX_B : cfg.max_chars;

   // A byte following a document's last byte sees the cleared document state.
   assign cur_phase = new_doc_ff ? PHASE_SEEK : phase_ff;
   assign cur_bss = new_doc_ff ? 8'h00 : bss_ff;
   assign cur_depth = new_doc_ff ? 9'h000 : depth_ff;
   assign cur_stopped = new_doc_ff ? 1'b0 : stopped_ff;
   assign cur_kept = new_doc_ff ? 8'h00 : kept_ff;
   assign bss_inc = (cur_bss == COUNT_MAX) ? cur_bss : cur_bss + 8'd1;

   assign start_ok = (&start_hits) && (bss_inc >= 8'(sl));
   assign end_ok = (&end_hits) && (bss_inc >= 8'(el));
   assign end_tap = hist_tap[TAG_IDX_W'(el - TAG_LEN_W'(1))];
   assign copy_ok = (cur_bss < win) && !cur_stopped;

   assign cell_ctl.byte_shift = doc_acc;
   assign cell_ctl.hist_shift = doc_acc && (cur_phase == PHASE_COLLECT);
   assign cell_ctl.hist_clear = doc_acc && (new_doc_ff || (cur_phase == PHASE_SEEK && start_ok));
   assign cell_ctl.case_fold = cfg.case_fold;

   for (genvar g = 0; g < TAG_BYTES; g++) begin : g_cell
      logic [7:0] chain_byte;
      logic [7:0] chain_hist;
      logic zero_byte;

      if (g == 0) begin : g_head
         assign chain_byte = req_doc_byte;
         assign chain_hist = cur_kept;
         assign zero_byte = 1'b0;
      end else begin : g_body
         assign chain_byte = recent[g-1];
         assign chain_hist = hist[g-1];
         assign zero_byte = new_doc_ff;
      end

      tete_cell u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(cell_ctl),
         .cell_idx(TAG_IDX_W'(g)),
         .start_pattern(cfg.start_pattern),
         .start_len(sl),
         .end_pattern(cfg.end_pattern),
         .end_len(el),
         .chain_byte(chain_byte),
         .zero_byte(zero_byte),
         .chain_hist(chain_hist),
         .byte_out(recent[g]),
         .hist_out(hist[g]),
         .hist_tap(hist_tap[g]),
         .start_hit(start_hits[g]),
         .end_hit(end_hits[g])
      );
   end

   always_comb begin
      phase_in = phase_ff;
      if (doc_acc) begin
         case (cur_phase)
            PHASE_SEEK: phase_in = start_ok ? PHASE_COLLECT : PHASE_SEEK;
            PHASE_COLLECT: phase_in = end_ok ? PHASE_DONE : PHASE_COLLECT;
            PHASE_DONE: phase_in = PHASE_DONE;
            default: phase_in = PHASE_SEEK;
         endcase
      end
   end

   always_comb begin
      bss_in = bss_ff;
      depth_in = depth_ff;
      stopped_in = stopped_ff;
      kept_in = kept_ff;
      new_doc_in = new_doc_ff;
      store_wr = 1'b0;
      if (doc_acc) begin
         bss_in = cur_bss;
         depth_in = cur_depth;
         stopped_in = cur_stopped;
         kept_in = cur_kept;
         new_doc_in = req_doc_last;
         case (cur_phase)
            PHASE_SEEK: begin
               bss_in = bss_inc;
               if (start_ok) begin
                  bss_in = 8'h00;
                  depth_in = 9'h000;
                  stopped_in = 1'b0;
                  kept_in = 8'h00;
               end
            end
            PHASE_COLLECT: begin
               bss_in = bss_inc;
               if (copy_ok) begin
                  if (req_doc_byte == CHAR_LT) begin
                     if (cur_depth != DEPTH_MAX) begin
                        depth_in = cur_depth + 9'd1;
                     end
                  end else if (req_doc_byte == CHAR_GT) begin
                     if (cur_depth == 9'h000) begin
                        stopped_in = 1'b1;
                     end else begin
                        depth_in = cur_depth - 9'd1;
                     end
                  end else if (cur_depth == 9'h000) begin
                     store_wr = 1'b1;
                     kept_in = cur_kept + 8'd1;
                  end
               end
               // Characters of the end tag that were kept are withdrawn.
               if (end_ok) begin
                  kept_in = end_tap;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (doc_acc) begin
         s1_status_in = phase_in;
         s1_length_in = (phase_in == PHASE_DONE) ? kept_in : 8'h00;
      end else begin
         s1_status_in = phase_ff;
         s1_length_in = (phase_ff == PHASE_DONE) ? kept_ff : 8'h00;
      end
      s1_rd_ok_in = rd_acc && (phase_ff == PHASE_DONE) && (req_read_index < kept_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SEEK;
         bss_ff <= 8'h00;
         depth_ff <= 9'h000;
         stopped_ff <= 1'b0;
         kept_ff <= 8'h00;
         new_doc_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bss_ff <= bss_in;
         depth_ff <= depth_in;
         stopped_ff <= stopped_in;
         kept_ff <= kept_in;
         new_doc_ff <= new_doc_in;
         s1_valid_ff <= doc_acc || rd_acc;
      end
   end

   always_ff @(posedge clock) begin
      s1_length_ff <= s1_length_in;
      s1_status_ff <= s1_status_in;
      s1_rd_ok_ff <= s1_rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[RESULT_ADDR_W'(cur_kept)] <= req_doc_byte;
      end
      if (rd_acc) begin
         rdata_ff <= store_mem[RESULT_ADDR_W'(req_read_index)];
      end
   end

   assign push_data.result_char = s1_rd_ok_ff ? rdata_ff : 8'h00;
   assign push_data.result_length = s1_length_ff;
   assign push_data.status = s1_status_ff;

   tete_rsp_queue u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(s1_valid_ff),
      .push_data(push_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .fill(fill)
   );

   assign rsp_result_char = rsp_data.result_char;
   assign rsp_result_length = rsp_data.result_length;
   assign rsp_status = rsp_data.status;

endmodule

// ----- rtl/core/tete_csr.sv -----
// Configuration register file behind an APB-style port.
// Depends on tete_pkg for register indexes and the cfg_type bundle.
module tete_csr import tete_pkg::*; (
   input logic clock,
   input logic reset,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic pready,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign pready = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];
   assign wr_en = psel && penable && pwrite && pready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_START_PATTERN: cfg_in.start_pattern = pwdata;
            CSR_START_LENGTH: cfg_in.start_length = pwdata[3:0];
            CSR_END_PATTERN: cfg_in.end_pattern = pwdata;
            CSR_END_LENGTH: cfg_in.end_length = pwdata[3:0];
            CSR_MAX_CHARS: cfg_in.max_chars = pwdata[7:0];
            CSR_CASE_FOLD: cfg_in.case_fold = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_START_PATTERN: prdata = cfg_ff.start_pattern;
         CSR_START_LENGTH: prdata = CSR_DATA_W'(cfg_ff.start_length);
         CSR_END_PATTERN: prdata = cfg_ff.end_pattern;
         CSR_END_LENGTH: prdata = CSR_DATA_W'(cfg_ff.end_length);
         CSR_MAX_CHARS: prdata = CSR_DATA_W'(cfg_ff.max_chars);
         CSR_CASE_FOLD: prdata = CSR_DATA_W'(cfg_ff.case_fold);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pattern <= '0;
         cfg_ff.start_length <= 4'd7;
         cfg_ff.end_pattern <= '0;
         cfg_ff.end_length <= 4'd6;
         cfg_ff.max_chars <= 8'd240;
         cfg_ff.case_fold <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/tete_cell.sv -----
// One cell of the recent-byte row: a byte and a kept-count history entry, plus
// the per-position compare against the start and end tags. Depends on tete_pkg.
module tete_cell import tete_pkg::*; (
   input logic clock,
   input logic reset,
   input cell_ctl_type ctl,
   input logic [TAG_IDX_W-1:0] cell_idx,
   input logic [63:0] start_pattern,
   input logic [TAG_LEN_W-1:0] start_len,
   input logic [63:0] end_pattern,
   input logic [TAG_LEN_W-1:0] end_len,
   input logic [7:0] chain_byte,
   input logic zero_byte,
   input logic [7:0] chain_hist,
   output logic [7:0] byte_out,
   output logic [7:0] hist_out,
   output logic [7:0] hist_tap,
   output logic start_hit,
   output logic end_hit
);

   logic [7:0] recent_ff;
   logic [7:0] recent_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [7:0] shift_byte;
   logic [TAG_LEN_W-1:0] pos;
   logic [TAG_IDX_W-1:0] start_sel;
   logic [TAG_IDX_W-1:0] end_sel;
   logic start_active;
   logic end_active;

   assign pos = TAG_LEN_W'(cell_idx);
   assign shift_byte = zero_byte ? 8'h00 : chain_byte;

   // The compare looks at the byte this cell holds after the shift.
   assign start_active = pos < start_len;
   assign end_active = pos < end_len;
   assign start_sel = TAG_IDX_W'(start_len - TAG_LEN_W'(1) - pos);
   assign end_sel = TAG_IDX_W'(end_len - TAG_LEN_W'(1) - pos);
   assign start_hit = !start_active ||
      (fold_char(pattern_byte(start_pattern, start_sel), ctl.case_fold) ==
       fold_char(shift_byte, ctl.case_fold));
   assign end_hit = !end_active ||
      (fold_char(pattern_byte(end_pattern, end_sel), ctl.case_fold) ==
       fold_char(shift_byte, ctl.case_fold));

   always_comb begin
      recent_in = recent_ff;
      if (ctl.byte_shift) begin
         recent_in = shift_byte;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.hist_clear) begin
         count_in = 8'h00;
      end else if (ctl.hist_shift) begin
         count_in = chain_hist;
      end
   end

   assign byte_out = recent_ff;
   assign hist_out = count_ff;
   assign hist_tap = chain_hist;

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= 8'h00;
         count_ff <= 8'h00;
      end else begin
         recent_ff <= recent_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/tete_rsp_queue.sv -----
// Small result queue that decouples the result channel from the scan pipeline.
// Depends on tete_pkg for rsp_type and the queue depth.
module tete_rsp_queue import tete_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input rsp_type push_data,
   input logic rsp_stall,
   output logic rsp_valid,
   output rsp_type rsp_data,
   output logic [RSP_CNT_W-1:0] fill
);

   rsp_type entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff;
   logic [RSP_CNT_W-1:0] cnt_in;
   logic pop;

   function automatic logic [RSP_PTR_W-1:0] next_ptr(input logic [RSP_PTR_W-1:0] p);
      return (p == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : p + RSP_PTR_W'(1);
   endfunction

   assign rsp_valid = cnt_ff != '0;
   assign rsp_data = entry_ff[rd_ptr_ff];
   assign fill = cnt_ff;
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + RSP_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/tete_checker.sv -----
// Port-level checks on the result channel of the extractor, bound to the top level.
// Depends on tete_pkg and tag_enclosed_text_extractor.
module tete_checker import tete_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [7:0] rsp_result_char,
   input logic [7:0] rsp_result_length,
   input logic [1:0] rsp_status
);

   // A length is reported only once the end tag has been seen.
   a_len_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != PHASE_DONE) |-> rsp_result_length == 8'h00)
      else $error("result length reported before the end tag");

   // A character can only come from inside the extracted text.
   a_char_in_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_char != 8'h00) |->
         (rsp_result_length != 8'h00) && (rsp_status == PHASE_DONE))
      else $error("result character outside the extracted text");

   a_len_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_length <= WINDOW_MAX_B)
      else $error("result length beyond the copy window");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_char) &&
         $stable(rsp_result_length) && $stable(rsp_status))
      else $error("stalled result beat changed");

endmodule

bind tag_enclosed_text_extractor tete_checker u_tete_checker (.*);

// ----- dv/tag_enclosed_text_extractor_tb.sv -----
// Self-checking testbench for the tag-enclosed text extractor: streams documents and
// result reads, predicts every result beat and compares it field by field.
// Depends on tete_pkg and the tag_enclosed_text_extractor top level.
module tag_enclosed_text_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tete_pkg::*;

   typedef struct packed {
      logic rtype;
      logic [7:0] dbyte;
      logic dlast;
      logic [7:0] ridx;
   } scan_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = 1'b0;
   logic [7:0] req_doc_byte = 8'h00;
   logic req_doc_last = 1'b0;
   logic [7:0] req_read_index = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_result_char;
   logic [7:0] rsp_result_length;
   logic [1:0] rsp_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   scan_beat_type beat_queue [$];
   scan_beat_type next_beat;
   rsp_type results_due [$];
   rsp_type due;
   int unsigned beats_queued = 0;
   int unsigned beats_accepted = 0;
   int unsigned mismatches = 0;
   int unsigned send_idle_pct = 11;
   int unsigned recv_idle_pct = 73;
   logic send_pause = 1'b0;
   logic rsp_hold = 1'b0;

   cfg_type cfg_shadow;
   logic [7:0] recent [TAG_BYTES];
   logic [7:0] kept_hist [TAG_BYTES];
   logic [7:0] text_store [RESULT_DEPTH];
   phase_type scan_state;
   int unsigned since_start;
   int unsigned bracket_level;
   int unsigned kept;
   logic copy_halted;
   logic doc_closed;

   tag_enclosed_text_extractor u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_doc_byte(req_doc_byte),
      .req_doc_last(req_doc_last),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_char(rsp_result_char),
      .rsp_result_length(rsp_result_length),
      .rsp_status(rsp_status),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned tag_len(input logic [3:0] len);
      if (len == 4'd0) return 1;
      if (len > 4'(TAG_BYTES)) return TAG_BYTES;
      return len;
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      if (cfg_shadow.case_fold && c >= "a" && c <= "z") return c - 8'h20;
      return c;
   endfunction

   function automatic logic tag_seen(input logic [63:0] pattern, input int unsigned len);
      int unsigned j;
      for (j = 0; j < len; j++) begin
         if (upcase(pattern[8*j +: 8]) != upcase(recent[len-1-j])) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void clear_document();
      int i;
      for (i = 0; i < TAG_BYTES; i++) begin
         recent[i] = 8'h00;
         kept_hist[i] = 8'h00;
      end
      scan_state = PHASE_SEEK;
      since_start = 0;
      bracket_level = 0;
      copy_halted = 1'b0;
      kept = 0;
      doc_closed = 1'b0;
   endfunction

   function automatic void scan_doc_byte(input logic [7:0] b);
      int i;
      int unsigned window;
      int unsigned offset;
      int unsigned el;
      if (doc_closed) clear_document();
      for (i = TAG_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (scan_state == PHASE_SEEK) begin
         if (since_start < 255) since_start++;
         if (since_start >= tag_len(cfg_shadow.start_length) &&
             tag_seen(cfg_shadow.start_pattern, tag_len(cfg_shadow.start_length))) begin
            scan_state = PHASE_COLLECT;
            since_start = 0;
            bracket_level = 0;
            copy_halted = 1'b0;
            kept = 0;
            for (i = 0; i < TAG_BYTES; i++) kept_hist[i] = 8'h00;
         end
      end else if (scan_state == PHASE_COLLECT) begin
         el = tag_len(cfg_shadow.end_length);
         window = cfg_shadow.max_chars;
         if (window > WINDOW_MAX) window = WINDOW_MAX;
         offset = since_start;
         for (i = TAG_BYTES - 1; i > 0; i--) kept_hist[i] = kept_hist[i-1];
         kept_hist[0] = 8'(kept);
         if (offset < window && !copy_halted) begin
            if (b == CHAR_LT) begin
               if (bracket_level < 511) bracket_level++;
            end else if (b == CHAR_GT) begin
               if (bracket_level == 0) copy_halted = 1'b1;
               else bracket_level--;
            end else if (bracket_level == 0 && kept < RESULT_DEPTH) begin
               text_store[kept] = b;
               kept++;
            end
         end
         if (since_start < 255) since_start++;
         if (since_start >= el && tag_seen(cfg_shadow.end_pattern, el)) begin
            kept = kept_hist[el-1];
            scan_state = PHASE_DONE;
         end
      end
   endfunction

   function automatic rsp_type extractor_step(input scan_beat_type s);
      rsp_type r;
      int unsigned len;
      r = '0;
      if (!s.rtype) begin
         scan_doc_byte(s.dbyte);
         if (s.dlast) doc_closed = 1'b1;
      end
      len = (scan_state == PHASE_DONE) ? kept : 0;
      if (s.rtype && s.ridx < len) r.result_char = text_store[s.ridx];
      r.result_length = 8'(len);
      r.status = scan_state;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            results_due.push_back(extractor_step({req_type, req_doc_byte, req_doc_last,
                                                  req_read_index}));
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (beat_queue.size() != 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               next_beat = beat_queue.pop_front();
               req_valid <= 1'b1;
               req_type <= next_beat.rtype;
               req_doc_byte <= next_beat.dbyte;
               req_doc_last <= next_beat.dlast;
               req_read_index <= next_beat.ridx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: result beat with none expected: char %h length %0d status %0d",
                        $time, rsp_result_char, rsp_result_length, rsp_status);
               mismatches++;
            end else begin
               due = results_due.pop_front();
               if (rsp_result_char !== due.result_char) begin
                  $display("%0t: result_char expected %h actual %h",
                           $time, due.result_char, rsp_result_char);
                  mismatches++;
               end
               if (rsp_result_length !== due.result_length) begin
                  $display("%0t: result_length expected %0d actual %0d",
                           $time, due.result_length, rsp_result_length);
                  mismatches++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, due.status, rsp_status);
                  mismatches++;
               end
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL tag_enclosed_text_extractor");
      $finish;
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_START_PATTERN: cfg_shadow.start_pattern = value;
         CSR_START_LENGTH: cfg_shadow.start_length = value[3:0];
         CSR_END_PATTERN: cfg_shadow.end_pattern = value;
         CSR_END_LENGTH: cfg_shadow.end_length = value[3:0];
         CSR_MAX_CHARS: cfg_shadow.max_chars = value[7:0];
         CSR_CASE_FOLD: cfg_shadow.case_fold = value[0];
         default: ;
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      beat_queue.push_back({1'b0, b, last, 8'($urandom)});
      beats_queued++;
   endtask

   task automatic push_read(input logic [7:0] idx);
      beat_queue.push_back({1'b1, 8'($urandom), 1'($urandom), idx});
      beats_queued++;
   endtask

   function automatic logic [7:0] letter();
      int unsigned r;
      r = $urandom_range(51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic logic [7:0] tag_char(input logic [63:0] pattern, input int unsigned j);
      logic [7:0] c;
      c = pattern[8*j +: 8];
      if (cfg_shadow.case_fold && $urandom_range(1) &&
          ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) c = c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] text_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return CHAR_LT;
      if (r < 16) return CHAR_GT;
      if (r < 26) return tag_char(cfg_shadow.start_pattern,
                                  $urandom_range(tag_len(cfg_shadow.start_length) - 1));
      if (r < 38) return tag_char(cfg_shadow.end_pattern,
                                  $urandom_range(tag_len(cfg_shadow.end_length) - 1));
      if (r < 50) return 8'($urandom);
      return letter();
   endfunction

   function automatic logic [63:0] tag_letters();
      logic [63:0] p;
      int unsigned j;
      int unsigned r;
      for (j = 0; j < 8; j++) begin
         r = $urandom_range(9);
         p[8*j +: 8] = (r == 0) ? CHAR_LT : (r == 1) ? "/" : (r == 2) ? CHAR_GT : letter();
      end
      return p;
   endfunction

   task automatic push_document();
      logic [7:0] txt [$];
      int unsigned shape;
      int unsigned n_body;
      int unsigned reads;
      int unsigned j;
      logic plain;
      shape = $urandom_range(99);
      plain = ($urandom_range(3) == 0);
      if ($urandom_range(29) == 0) n_body = $urandom_range(300, 200);
      else n_body = $urandom_range(24);
      if (shape < 10) begin
         for (j = 0; j <= n_body; j++) txt.push_back(text_byte());
      end else begin
         for (j = $urandom_range(6); j > 0; j--) txt.push_back(text_byte());
         for (j = 0; j < tag_len(cfg_shadow.start_length); j++)
            txt.push_back(tag_char(cfg_shadow.start_pattern, j));
         for (j = 0; j < n_body; j++) txt.push_back(plain ? letter() : text_byte());
         if (shape >= 22) begin
            for (j = 0; j < tag_len(cfg_shadow.end_length); j++)
               txt.push_back(tag_char(cfg_shadow.end_pattern, j));
         end
         for (j = $urandom_range(3); j > 0; j--) txt.push_back(text_byte());
      end
      for (j = 0; j < txt.size(); j++) begin
         push_byte(txt[j], j == txt.size() - 1);
         if ($urandom_range(99) < 8) push_read(8'($urandom));
      end
      reads = (n_body + 2 < 24) ? n_body + 2 : 24;
      for (j = 0; j < reads; j++) push_read(8'(j));
      push_read($urandom_range(1) ? 8'hFF : 8'($urandom_range(241, 200)));
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (beats_accepted != beats_queued || results_due.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input int unsigned p);
      logic [63:0] sp, ep;
      logic [3:0] sl, el;
      logic [7:0] mc;
      logic cf;
      case (p)
         1: begin
            sp = 64'h3E423C; sl = 4'd3; ep = 64'h3E422F3C; el = 4'd4;
            mc = 8'd240; cf = 1'b1;
         end
         2: begin
            sp = {$urandom, $urandom}; sl = 4'd0; ep = tag_letters(); el = 4'd15;
            mc = 8'd0; cf = 1'b0;
         end
         3: begin
            sp = 64'hFFFF_FFFF_FFFF_FFFF; sl = 4'd8; ep = 64'h2E; el = 4'd1;
            mc = 8'd255; cf = 1'b0;
         end
         4: begin
            sp = tag_letters(); sl = 4'($urandom_range(8, 1));
            ep = tag_letters(); el = 4'($urandom_range(8, 1));
            mc = 8'($urandom_range(20, 1)); cf = 1'($urandom_range(1));
         end
         default: begin
            sp = 64'h6261; sl = 4'd2; ep = 64'h7A59; el = 4'd2;
            mc = 8'd1; cf = 1'b1;
         end
      endcase
      write_register(CSR_START_PATTERN, sp);
      write_register(CSR_START_LENGTH, 64'(sl));
      write_register(CSR_END_PATTERN, ep);
      write_register(CSR_END_LENGTH, 64'(el));
      write_register(CSR_MAX_CHARS, 64'(mc));
      write_register(CSR_CASE_FOLD, 64'(cf));
   endtask

   initial begin : stimulus
      string directed_doc;
      int unsigned p;
      int unsigned j;
      int unsigned mark;
      cfg_shadow = '{start_pattern: 64'h0, start_length: 4'd7, end_pattern: 64'h0,
                     end_length: 4'd6, max_chars: 8'd240, case_fold: 1'b1};
      clear_document();
      directed_doc = "<b>A<i>z</i>q>r</B>s";
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < 6; p++) begin
         if (p > 0) apply_setting(p);
         send_idle_pct <= (p < 2) ? 11 : (p < 4) ? 73 : 0;
         recv_idle_pct <= (p < 2) ? 73 : (p < 4) ? 11 : 0;
         if (p == 1) begin
            push_read(8'd0);
            push_byte(8'h00, 1'b0);
            push_byte(8'hFF, 1'b0);
            for (j = 0; j < directed_doc.len(); j++)
               push_byte(directed_doc[j], j == directed_doc.len() - 1);
            push_read(8'd0);
            push_read(8'd2);
            push_read(8'd3);
            push_read(8'hFF);
         end
         mark = beats_queued;
         if (p == 4) begin
            while (beats_queued - mark < 165) push_document();
            while (beat_queue.size() > 60) @(posedge clock);
            send_pause <= 1'b1;
            @(posedge clock);
            while (req_valid || results_due.size() != 0) @(posedge clock);
            send_pause <= 1'b0;
         end
         while (beats_queued - mark < 330) push_document();
         if (p == 1) begin
            @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         wait_idle();
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("PASS tag_enclosed_text_extractor");
      end else begin
         $display("FAIL tag_enclosed_text_extractor");
      end
      $finish;
   end

endmodule
